// File: rtl/clne_pkg.sv
// Shared types and constants of the cell-list neighbor enumerator.
package clne_pkg;

    localparam int FIELD_LIMIT = 64;   // most cells a 6-bit col/row can name
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_COLS       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_ROWS       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_CELL_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_CELL_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUNDARY_MODE   = 3'd4;

    localparam logic [6:0]  RST_GRID_COLS   = 7'd64;
    localparam logic [6:0]  RST_GRID_ROWS   = 7'd64;
    localparam logic [31:0] RST_INV_CELL    = 32'h0001_0000;

    localparam logic BMODE_PERIODIC = 1'b0;
    localparam logic BMODE_WALLED   = 1'b1;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // effective grid setup seen by the datapath
    typedef struct packed {
        logic [6:0]  cols;      // 1..64
        logic [6:0]  rows;      // 1..64
        logic [31:0] inv_w;
        logic [31:0] inv_h;
        logic        bmode;
    } cfg_t;

    // one home cell waiting for enumeration
    typedef struct packed {
        logic       cmd;
        logic       oor;
        logic [5:0] col;
        logic [5:0] row;
    } qent_t;

endpackage

// File: rtl/clne_front.sv
// Front end: accepts positions and maps them to a home cell.
module clne_front #(
    parameter int QDEPTH = 4
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  clne_pkg::cfg_t                 cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,
    input  logic                           s_tuser,
    input  logic [$clog2(QDEPTH+1)-1:0]    q_count,
    output logic                           push,
    output clne_pkg::qent_t                push_data
);

    localparam int CW = $clog2(QDEPTH + 1);

    logic        v1_reg, v2_reg;
    logic        cmd1_reg, cmd2_reg;
    logic        negx1_reg, negy1_reg, negx2_reg, negy2_reg;
    logic [31:0] magx_reg, magy_reg;
    logic [31:0] qx_reg, qy_reg;
    logic [63:0] prod_x, prod_y;
    logic [CW:0] used;
    logic        acc;
    logic [6:0]  hx, hy;
    logic [31:0] px, py;

    // oor flag on bit 6, coordinate below
    function automatic logic [6:0] axis_home(input logic [31:0] q, input logic neg,
                                             input logic [6:0] size);
        logic       oor;
        logic [6:0] qn;
        logic [7:0] two_s;
        logic [7:0] qc;
        logic [5:0] h;
        oor   = 1'b0;
        qn    = '0;
        two_s = {size, 1'b0};
        qc    = '0;
        h     = '0;
        if (neg) begin
            oor = q > {25'd0, size};
            qn  = oor ? size : q[6:0];
            h   = (qn == 7'd0 || qn == size) ? 6'd0 : 6'(size - qn);
        end else begin
            oor = q >= {24'd0, two_s};
            qc  = oor ? 8'(two_s - 8'd1) : q[7:0];
            h   = (qc >= {1'b0, size}) ? 6'(qc - {1'b0, size}) : 6'(qc);
        end
        return {oor, h};
    endfunction

    // credit: queue words plus words in flight never exceed the queue depth
    assign used     = (CW+1)'(q_count) + (CW+1)'(v1_reg) + (CW+1)'(v2_reg);
    assign s_tready = aresetn && (used < (CW+1)'(QDEPTH));
    assign acc      = s_tvalid && s_tready;

    assign px = s_tdata[31:0];
    assign py = s_tdata[63:32];

    assign prod_x = {32'd0, magx_reg} * {32'd0, cfg.inv_w};
    assign prod_y = {32'd0, magy_reg} * {32'd0, cfg.inv_h};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= acc;
            v2_reg <= v1_reg;
        end
        cmd1_reg  <= s_tuser;
        negx1_reg <= px[31];
        negy1_reg <= py[31];
        magx_reg  <= px[31] ? 32'(32'd0 - px) : px;
        magy_reg  <= py[31] ? 32'(32'd0 - py) : py;
        cmd2_reg  <= cmd1_reg;
        negx2_reg <= negx1_reg;
        negy2_reg <= negy1_reg;
        qx_reg    <= prod_x[63:32];
        qy_reg    <= prod_y[63:32];
    end

    assign hx = axis_home(qx_reg, negx2_reg, cfg.cols);
    assign hy = axis_home(qy_reg, negy2_reg, cfg.rows);

    assign push           = v2_reg;
    assign push_data.cmd  = cmd2_reg;
    assign push_data.oor  = hx[6] | hy[6];
    assign push_data.col  = hx[5:0];
    assign push_data.row  = hy[5:0];

endmodule

// File: rtl/clne_fifo.sv
// Small register queue between front and back end.
module clne_fifo #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         rd_valid,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    assign do_wr    = wr_en && (cnt_reg != CW'(DEPTH));
    assign do_rd    = rd_en && (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign rd_valid = (cnt_reg != '0);
    assign count    = cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) wp_reg <= inc(wp_reg);
            if (do_rd) rp_reg <= inc(rp_reg);
            if (do_wr && !do_rd) cnt_reg <= CW'(cnt_reg + 1'b1);
            else if (do_rd && !do_wr) cnt_reg <= CW'(cnt_reg - 1'b1);
        end
        if (do_wr) mem_reg[wp_reg] <= wr_data;
    end

endmodule

// File: rtl/clne_back.sv
// Back end: walks the neighbor offsets of each home cell and drives the result port.
module clne_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  clne_pkg::cfg_t   cfg,
    input  logic             q_valid,
    input  clne_pkg::qent_t  q_data,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam logic [3:0] HOME_STEP = 4'd8;

    typedef enum logic [1:0] {
        OFF_MINUS,
        OFF_ZERO,
        OFF_PLUS
    } off_t;

    typedef struct packed {
        off_t dx;
        off_t dy;
    } offs_t;

    // neighbor order: dy -1..1 outer, dx -1..1 inner, self skipped; home at the end
    function automatic offs_t step_offs(input logic [3:0] s);
        offs_t o;
        o = '{dx: OFF_ZERO, dy: OFF_ZERO};
        case (s)
            4'd0: o = '{dx: OFF_MINUS, dy: OFF_MINUS};
            4'd1: o = '{dx: OFF_ZERO,  dy: OFF_MINUS};
            4'd2: o = '{dx: OFF_PLUS,  dy: OFF_MINUS};
            4'd3: o = '{dx: OFF_MINUS, dy: OFF_ZERO};
            4'd4: o = '{dx: OFF_PLUS,  dy: OFF_ZERO};
            4'd5: o = '{dx: OFF_MINUS, dy: OFF_PLUS};
            4'd6: o = '{dx: OFF_ZERO,  dy: OFF_PLUS};
            4'd7: o = '{dx: OFF_PLUS,  dy: OFF_PLUS};
            default: o = '{dx: OFF_ZERO, dy: OFF_ZERO};
        endcase
        return o;
    endfunction

    // ok flag on bit 6, coordinate below
    function automatic logic [6:0] axis_move(input logic [5:0] h, input off_t d,
                                             input logic [6:0] size, input logic walled);
        logic       ok;
        logic [5:0] c;
        ok = 1'b1;
        c  = h;
        case (d)
            OFF_MINUS: begin
                if (h == 6'd0) begin
                    ok = !walled;
                    c  = 6'(size - 7'd1);
                end else begin
                    c = 6'(h - 6'd1);
                end
            end
            OFF_PLUS: begin
                if ({1'b0, h} + 7'd1 == size) begin
                    ok = !walled;
                    c  = 6'd0;
                end else begin
                    c = 6'(h + 6'd1);
                end
            end
            default: c = h;
        endcase
        return {ok, c};
    endfunction

    logic [3:0]  step_reg, step_next;
    logic [3:0]  cur_step;
    logic        adv, at_home;
    offs_t       offs;
    logic [6:0]  mc, mr;
    logic        cand_ok;
    logic [11:0] cand_idx;
    logic        walled;

    logic        mvalid_reg, mvalid_next;
    logic [23:0] mdata_reg;
    logic [1:0]  muser_reg;

    assign walled   = (cfg.bmode == clne_pkg::BMODE_WALLED);
    assign cur_step = (q_data.cmd == clne_pkg::CMD_QUERY) ? step_reg : HOME_STEP;
    assign at_home  = (cur_step == HOME_STEP);
    assign offs     = step_offs(cur_step);
    assign mc       = axis_move(q_data.col, offs.dx, cfg.cols, walled);
    assign mr       = axis_move(q_data.row, offs.dy, cfg.rows, walled);
    assign cand_ok  = mc[6] & mr[6];
    assign cand_idx = 12'({6'd0, mr[5:0]} * {5'd0, cfg.cols} + {6'd0, mc[5:0]});

    // one offset slot per cycle while the output word is free or leaving
    assign adv = q_valid && (!mvalid_reg || m_tready);
    assign pop = adv && at_home;

    always_comb begin
        step_next   = step_reg;
        mvalid_next = mvalid_reg && !m_tready;
        if (adv) begin
            step_next   = at_home ? 4'd0 : 4'(step_reg + 4'd1);
            mvalid_next = cand_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            step_reg   <= step_next;
            mvalid_reg <= mvalid_next;
        end
        if (adv && cand_ok) begin
            mdata_reg <= {mr[5:0], mc[5:0], cand_idx};
            muser_reg <= {q_data.oor, at_home};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;
    assign m_tlast  = muser_reg[0];

endmodule

// File: rtl/cell_list_neighbor_enumerator.sv
// Cell-list neighbor enumerator: top level with configuration registers.
//
// Maps a signed Q16.16 (x, y) position to a cell of a uniform 2-D grid of up to
// 64 x 64 cells and streams out cell words. A place word (tuser 0) gives the home
// cell alone; a query word (tuser 1) gives the eight neighbors in row-major offset
// order, then the home cell with tlast set. The front end takes one input word
// per cycle while the queue has room, registers the position magnitude and the
// scaled coordinate in turn, and pushes the home cell into a 4-entry queue. The
// back end walks one offset slot at a time and so sets the sustained rate: nine
// slots for a query, one for a place, holding while the result port stalls. In
// walled mode a dropped neighbor still takes its slot, so a query walks all nine
// slots however few words it yields. Write the registers only while the block is idle.
module cell_list_neighbor_enumerator #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_we,
    input  logic [clne_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [clne_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [63:0]                            s_tdata,   // pos_x, pos_y
    input  logic                                   s_tuser,   // cmd
    // result stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [23:0]                            m_tdata,   // cell_index, cell_col, cell_row
    output logic [1:0]                             m_tuser,   // is_home, out_of_range
    output logic                                   m_tlast
);

    localparam int LIM_COLS = (MAX_COLS < clne_pkg::FIELD_LIMIT) ? MAX_COLS
                                                                 : clne_pkg::FIELD_LIMIT;
    localparam int LIM_ROWS = (MAX_ROWS < clne_pkg::FIELD_LIMIT) ? MAX_ROWS
                                                                 : clne_pkg::FIELD_LIMIT;
    localparam int QD  = clne_pkg::QUEUE_DEPTH;
    localparam int QCW = $clog2(QD + 1);

    logic [6:0]  grid_cols_reg, grid_rows_reg;
    logic [31:0] inv_w_reg, inv_h_reg;
    logic        bmode_reg;

    clne_pkg::cfg_t  cfg;
    clne_pkg::qent_t push_data, q_data;
    logic            push, pop, q_valid;
    logic [QCW-1:0]  q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= clne_pkg::RST_GRID_COLS;
            grid_rows_reg <= clne_pkg::RST_GRID_ROWS;
            inv_w_reg     <= clne_pkg::RST_INV_CELL;
            inv_h_reg     <= clne_pkg::RST_INV_CELL;
            bmode_reg     <= clne_pkg::BMODE_PERIODIC;
        end else if (cfg_we) begin
            case (cfg_addr)
                clne_pkg::REG_GRID_COLS:       grid_cols_reg <= cfg_wdata[6:0];
                clne_pkg::REG_GRID_ROWS:       grid_rows_reg <= cfg_wdata[6:0];
                clne_pkg::REG_INV_CELL_WIDTH:  inv_w_reg     <= cfg_wdata;
                clne_pkg::REG_INV_CELL_HEIGHT: inv_h_reg     <= cfg_wdata;
                clne_pkg::REG_BOUNDARY_MODE:   bmode_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // zero means one cell; large sizes saturate
    assign cfg.cols  = (grid_cols_reg == 7'd0) ? 7'd1 :
                       (grid_cols_reg > 7'(LIM_COLS)) ? 7'(LIM_COLS) : grid_cols_reg;
    assign cfg.rows  = (grid_rows_reg == 7'd0) ? 7'd1 :
                       (grid_rows_reg > 7'(LIM_ROWS)) ? 7'(LIM_ROWS) : grid_rows_reg;
    assign cfg.inv_w = inv_w_reg;
    assign cfg.inv_h = inv_h_reg;
    assign cfg.bmode = bmode_reg;

    clne_front #(
        .QDEPTH (QD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    clne_fifo #(
        .WIDTH ($bits(clne_pkg::qent_t)),
        .DEPTH (QD)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push),
        .wr_data  (push_data),
        .rd_en    (pop),
        .rd_data  (q_data),
        .rd_valid (q_valid),
        .count    (q_count)
    );

    clne_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/clne_checker.sv
// Port-level checks for the cell-list neighbor enumerator, bound to the top level.
module clne_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [23:0]                         m_tdata,
    input logic [1:0]                          m_tuser,
    input logic                                m_tlast
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // the home cell closes every item, and only it does
    a_home_last: assert property (@(posedge aclk)
        m_tvalid |-> (m_tuser[0] == m_tlast))
        else $error("home flag and tlast disagree");

    // range flag is the same on all words of one item
    a_oor_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |-> m_tuser[1] == $past(m_tuser[1]))
        else $error("out_of_range changed inside an item");

    // no input taken during reset, no result word right after it
    a_reset: assert property (@(posedge aclk)
        !aresetn |-> !s_tready ##1 !m_tvalid)
        else $error("stream active after reset");

endmodule

bind cell_list_neighbor_enumerator clne_checker u_clne_checker (.*);
